// ===== hw/rtl/mbrf_pkg.sv =====
// Types, constants and CRC table function shared by the request framer.
`timescale 1ns / 1ps

package mbrf_pkg;

   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  SLAVE_ID_RESET    = 8'h01;

   // Frame byte positions in transmit order
   localparam logic [IDX_W-1:0] BYTE_SLAVE   = 3'd0;
   localparam logic [IDX_W-1:0] BYTE_FUNC    = 3'd1;
   localparam logic [IDX_W-1:0] BYTE_ADDR_HI = 3'd2;
   localparam logic [IDX_W-1:0] BYTE_ADDR_LO = 3'd3;
   localparam logic [IDX_W-1:0] BYTE_CNT_HI  = 3'd4;
   localparam logic [IDX_W-1:0] BYTE_CNT_LO  = 3'd5;
   localparam logic [IDX_W-1:0] BYTE_CRC_LO  = 3'd6;
   localparam logic [IDX_W-1:0] BYTE_CRC_HI  = 3'd7;

   typedef struct packed {
      logic [15:0] start_address;
      logic [15:0] register_count;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_payload_type;

   // One entry of the byte-wise CRC-16/MODBUS table
   function automatic logic [15:0] crc_table(input logic [7:0] index);
      logic [15:0] crc;
      crc = {8'h00, index};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

// ===== hw/rtl/modbus_read_request_framer.sv =====
// Top level: frames a read-holding-registers request into eight bytes with CRC.
//
//   channel | ports                          | beat
//   --------+--------------------------------+---------------------------------
//   request | req_valid req_ready req_data   | start address, register count
//   result  | rsp_valid rsp_ready rsp_data   | one frame byte, last flag
//   config  | csr_write_enable csr_write_data| slave address
//
// Each request yields eight result beats, one per cycle unless the result side
// stalls; the next request is taken as the last byte of the frame goes out.
// The CRC advances one header byte per cycle through the table as they go out.
// A taken request loads the sequencer, which then loads the first byte to output.
// A stalled result holds in the output register and freezes the sequencer.
// Reset sets the slave address to 1 and clears all valid state.
`timescale 1ns / 1ps

module modbus_read_request_framer
   import mbrf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic [7:0]      csr_write_data
);

   logic [7:0]       slave_id_ff;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [15:0]      crc_ff, crc_in;
   req_payload_type  req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic       out_free;
   logic       advance;
   logic       finishing;
   logic       req_take;
   logic [7:0] cur_byte;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = busy_ff && out_free;
   assign finishing = advance && (byte_idx_ff == BYTE_CRC_HI);
   assign req_ready = !busy_ff || finishing;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      case (byte_idx_ff)
         BYTE_SLAVE:   cur_byte = slave_id_ff;
         BYTE_FUNC:    cur_byte = FUNC_READ_HOLDING;
         BYTE_ADDR_HI: cur_byte = req_ff.start_address[15:8];
         BYTE_ADDR_LO: cur_byte = req_ff.start_address[7:0];
         BYTE_CNT_HI:  cur_byte = req_ff.register_count[15:8];
         BYTE_CNT_LO:  cur_byte = req_ff.register_count[7:0];
         BYTE_CRC_LO:  cur_byte = crc_ff[7:0];
         BYTE_CRC_HI:  cur_byte = crc_ff[15:8];
         default:      cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      byte_idx_in  = byte_idx_ff;
      crc_in       = crc_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (out_free) begin
         rsp_valid_in = busy_ff;
      end

      if (advance) begin
         rsp_in.frame_byte = cur_byte;
         rsp_in.last_byte  = (byte_idx_ff == BYTE_CRC_HI);
         byte_idx_in       = byte_idx_ff + 1'b1;
         // advance the CRC only over the six header bytes
         if (byte_idx_ff <= BYTE_CNT_LO) begin
            crc_in = {8'h00, crc_ff[15:8]} ^ crc_table(crc_ff[7:0] ^ cur_byte);
         end
         if (byte_idx_ff == BYTE_CRC_HI) begin
            busy_in = 1'b0;
         end
      end

      if (req_take) begin
         busy_in     = 1'b1;
         byte_idx_in = BYTE_SLAVE;
         crc_in      = CRC_INIT;
         req_in      = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff  <= SLAVE_ID_RESET;
         busy_ff      <= 1'b0;
         byte_idx_ff  <= BYTE_SLAVE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            slave_id_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A taken request starts a frame at its first byte
   a_take_starts_frame: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (busy_ff && byte_idx_ff == BYTE_SLAVE))
      else $error("request taken but frame not started");

   // Sending the final byte yields a result beat flagged last
   a_last_flagged: assert property (@(posedge clock) disable iff (reset)
      finishing |=> (rsp_valid && rsp_data.last_byte))
      else $error("final frame byte not flagged last");

   // While the last byte waits, the sequencer is idle or at a fresh frame
   a_last_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_byte) |-> (!busy_ff || byte_idx_ff == BYTE_SLAVE))
      else $error("last byte out of step with sequencer");

   // Non-last result beats only come from an active frame
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_byte) |-> busy_ff)
      else $error("mid-frame byte without an active frame");

endmodule

// ===== bench/tb_modbus_read_request_framer.sv =====
// Testbench for the Modbus read request framer: directed and random requests against a CRC frame predictor.
`timescale 1ns / 1ps

module tb_modbus_read_request_framer;
   import mbrf_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned TAIL_CYCLES      = 20;
   localparam int unsigned RANDOM_PHASES    = 6;
   localparam int unsigned PHASE_REQUESTS   = 45;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   req_payload_type req_data         = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_enable = 1'b0;
   logic [7:0]      csr_write_data   = 8'h00;

   req_payload_type pending_requests[$];
   rsp_payload_type expected_frame_bytes[$];
   logic [7:0]      slave_id_model   = SLAVE_ID_RESET;
   int unsigned     requests_queued   = 0;
   int unsigned     requests_accepted = 0;
   int unsigned     mismatch_count    = 0;
   int unsigned     quiet_cycles      = 0;
   int unsigned     holds_asked       = 0;
   int unsigned     holds_granted     = 0;
   int unsigned     hold_left         = 0;
   int unsigned     send_gap          = 0;
   int unsigned     ready_gap         = 0;
   int unsigned     beat_count        = 0;
   bit              sender_idling     = 1'b0;
   bit              receiver_idling   = 1'b0;

   modbus_read_request_framer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   // Build the eight bytes of the request frame and queue them as expected beats
   function automatic void predict_frame(input req_payload_type r);
      logic [7:0]      frame [FRAME_LEN];
      logic [15:0]     crc;
      rsp_payload_type beat;
      frame[BYTE_SLAVE]   = slave_id_model;
      frame[BYTE_FUNC]    = FUNC_READ_HOLDING;
      frame[BYTE_ADDR_HI] = r.start_address[15:8];
      frame[BYTE_ADDR_LO] = r.start_address[7:0];
      frame[BYTE_CNT_HI]  = r.register_count[15:8];
      frame[BYTE_CNT_LO]  = r.register_count[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         crc = crc16_fold_byte(crc, frame[i]);
      end
      // CRC goes out low byte first
      frame[BYTE_CRC_LO] = crc[7:0];
      frame[BYTE_CRC_HI] = crc[15:8];
      for (int i = 0; i < FRAME_LEN; i++) begin
         beat.frame_byte = frame[i];
         beat.last_byte  = (i == FRAME_LEN - 1);
         expected_frame_bytes.push_back(beat);
      end
   endfunction

   function automatic logic [15:0] random_field();
      logic [15:0] one_hot;
      one_hot = 16'h0001 << $urandom_range(0, 15);
      case ($urandom_range(0, 9))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         2: begin
            return one_hot;
         end
         3: begin
            return ~one_hot;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] beat %0d: %s", $realtime, beat_count, what);
   endtask

   task automatic queue_request(input logic [15:0] address, input logic [15:0] count);
      req_payload_type r;
      r.start_address  = address;
      r.register_count = count;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // Wait until every queued request is taken and every frame has come out, then let the block settle
   task automatic drain_requests();
      while (requests_accepted != requests_queued || expected_frame_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slave_id(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (sender_idling && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_gap = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_granted != holds_asked) begin
         holds_granted++;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         ready_gap = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on request beats, check result beats, watch for a hang
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         slave_id_model <= SLAVE_ID_RESET;
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            slave_id_model <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            predict_frame(req_data);
            requests_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frame_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %b",
                                         rsp_data.frame_byte, rsp_data.last_byte));
            end else begin
               want = expected_frame_bytes.pop_front();
               if (rsp_data.frame_byte !== want.frame_byte) begin
                  report_mismatch($sformatf("frame_byte %02h, want %02h",
                                            rsp_data.frame_byte, want.frame_byte));
               end
               if (rsp_data.last_byte !== want.last_byte) begin
                  report_mismatch($sformatf("last_byte %b, want %b",
                                            rsp_data.last_byte, want.last_byte));
               end
            end
            beat_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, quiet_cycles);
            $display("modbus_read_request_framer: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset slave address, field extremes, single-bit and alternating patterns
      queue_request(16'h0000, 16'h0000);
      queue_request(16'hFFFF, 16'hFFFF);
      queue_request(16'h0000, 16'hFFFF);
      queue_request(16'hFFFF, 16'h0000);
      queue_request(16'h8000, 16'h0001);
      queue_request(16'h0001, 16'h8000);
      queue_request(16'hAAAA, 16'h5555);
      queue_request(16'h5555, 16'hAAAA);
      queue_request(16'h00FF, 16'hFF00);
      drain_requests();

      // Well-known frame: slave 0x11, address 0x006B, count 3, CRC 0x8776
      write_slave_id(8'h11);
      queue_request(16'h006B, 16'h0003);
      queue_request(16'h0000, 16'h007D);
      drain_requests();

      write_slave_id(8'h00);
      queue_request(16'h0000, 16'h0000);
      queue_request(16'hFFFF, 16'hFFFF);
      queue_request(16'h1234, 16'h0001);
      drain_requests();

      write_slave_id(8'hFF);
      queue_request(16'h0000, 16'h0000);
      queue_request(16'hFFFF, 16'hFFFF);
      queue_request(16'hFEDC, 16'h7FFF);
      drain_requests();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_slave_id(8'h80);
         end else begin
            write_slave_id(8'($urandom));
         end
         // Last phase runs at full rate on both sides
         sender_idling   = (phase < RANDOM_PHASES - 1) && (phase != 3);
         receiver_idling = (phase < RANDOM_PHASES - 1) && (phase != 1);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            queue_request(random_field(), random_field());
         end
         // Stall the result side long enough to back up the request side
         if (phase == 2) begin
            holds_asked++;
         end
         drain_requests();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_frame_bytes.size() == 0) begin
         $display("modbus_read_request_framer: match");
      end else begin
         $display("modbus_read_request_framer: mismatch");
      end
      $finish;
   end

endmodule
